[hdl/pia_pkg.sv]
// ----------------------------------------------------------------------------
// Process ID allocator package
// Sizes, operation and status codes, beat types and small search helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    localparam int NUM_IDS   = 256;
    localparam int ID_W      = 8;
    localparam int ID_BOUND  = (NUM_IDS < 256) ? NUM_IDS : 256;
    localparam int FIRST_ID  = 2;
    localparam int GRP_W     = 16;
    localparam int ROW_IDX_W = $clog2(GRP_W);
    localparam int NUM_GRP   = NUM_IDS / GRP_W;
    localparam int GRP_IDX_W = $clog2(NUM_GRP);
    localparam int OWNER_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int OP_W      = 2;

    localparam logic [GRP_W-1:0] ROW_RSVD = GRP_W'((1 << FIRST_ID) - 1);

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FORGET = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [ID_W-1:0]    target_id;
        logic [OWNER_W-1:0] owner_handle;
        logic [ID_W-1:0]    parent_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     result_id;
        logic [OWNER_W-1:0]  owner_out;
        logic [ID_W-1:0]     parent_out;
    } t_rsp;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [ID_W-1:0]    parent;
    } t_entry;

    function automatic logic [ROW_IDX_W-1:0] f_low_zero_row(input logic [GRP_W-1:0] v);
        logic [ROW_IDX_W-1:0] idx;
        idx = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = ROW_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] f_low_zero_grp(input logic [NUM_GRP-1:0] v);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_GRP - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[hdl/pia_req_if.sv]
// ----------------------------------------------------------------------------
// Process ID allocator request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pia_req_if import pia_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/pia_rsp_if.sv]
// ----------------------------------------------------------------------------
// Process ID allocator response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pia_rsp_if import pia_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/process_id_allocator_top.sv]
// ----------------------------------------------------------------------------
// Process ID allocator
// Lowest-free identifier table with owner and parent storage.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Forget passes the find and done states;
// allocate adds a pick state unless all groups are full, lookup a read state.
// The lowest-free search is a group pass over the per-group full flags, then a
// bit pass in the chosen occupancy row; lookup reads the 256 x 40 owner/parent
// memory through a registered read port. The output register frees the block
// for the next request while a response beat still waits. Occupancy sits in
// flip-flops cleared at reset, so the block takes requests right after reset.
`timescale 1ns / 1ps
`default_nettype none

module process_id_allocator_top import pia_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pia_req_if.sink    i_req,
    pia_rsp_if.source  o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int CMP_W = ID_W + 1;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    t_req                     r_req;
    t_rsp                     r_res;
    t_rsp                     r_out;
    logic                     r_out_valid;
    logic [GRP_W-1:0]         r_occ [NUM_GRP];
    logic [NUM_GRP-1:0]       r_grp_full;
    logic [GRP_IDX_W-1:0]     r_grp;
    t_entry                   r_rd;
    t_entry                   mem [NUM_IDS];

    logic [GRP_IDX_W-1:0]     tid_grp;
    logic [ROW_IDX_W-1:0]     tid_bit;
    logic [GRP_IDX_W-1:0]     row_sel;
    logic [GRP_W-1:0]         row_cur;
    logic [GRP_W-1:0]         row_eff;
    logic [ROW_IDX_W-1:0]     pick_bit;
    logic [GRP_W-1:0]         row_set;
    logic [GRP_W-1:0]         row_clr;
    logic [ID_W-1:0]          pick_id;
    logic                     tid_ok;
    logic                     tid_hit;
    logic                     all_full;
    logic                     out_free;
    logic                     req_beat;

    assign req_beat    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign tid_grp  = r_req.target_id[ID_W-1 -: GRP_IDX_W];
    assign tid_bit  = r_req.target_id[ROW_IDX_W-1:0];
    assign row_sel  = (r_state == S_PICK) ? r_grp : tid_grp;
    assign row_cur  = r_occ[row_sel];
    assign row_eff  = row_cur | ((row_sel == '0) ? ROW_RSVD : '0);
    assign pick_bit = f_low_zero_row(row_eff);
    assign row_set  = row_cur | (GRP_W'(1) << pick_bit);
    assign row_clr  = row_cur & ~(GRP_W'(1) << tid_bit);
    assign pick_id  = {r_grp, pick_bit};
    assign all_full = &r_grp_full;
    assign tid_ok   = (r_req.target_id != '0)
                   && (CMP_W'(r_req.target_id) < CMP_W'(ID_BOUND));
    assign tid_hit  = tid_ok && row_cur[tid_bit];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_beat) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                case (r_req.operation)
                    OP_ALLOC:  n_state = all_full ? S_DONE : S_PICK;
                    OP_LOOKUP: n_state = S_READ;
                    default:   n_state = S_DONE;
                endcase
            end
            S_PICK: n_state = S_DONE;
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_grp_full  <= '0;
            for (int g = 0; g < NUM_GRP; g++) begin
                r_occ[g] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_FIND) begin
                case (r_req.operation)
                    OP_ALLOC: begin
                        r_grp <= f_low_zero_grp(r_grp_full);
                        r_res <= '{ST_FULL, '0, '0, '0};
                    end
                    OP_FORGET: begin
                        if (tid_hit) begin
                            r_occ[tid_grp]      <= row_clr;
                            r_grp_full[tid_grp] <= 1'b0;
                            r_res <= '{ST_OK, '0, '0, '0};
                        end else begin
                            r_res <= '{ST_ABSENT, '0, '0, '0};
                        end
                    end
                    default: r_res <= '{ST_ABSENT, '0, '0, '0};
                endcase
            end
            if (r_state == S_PICK) begin
                r_occ[r_grp]      <= row_set;
                r_grp_full[r_grp] <= &(row_set | ((r_grp == '0) ? ROW_RSVD : '0));
                r_res <= '{ST_OK, pick_id, '0, '0};
            end
            if (r_state == S_READ) begin
                if (tid_hit) begin
                    r_res <= '{ST_OK, r_req.target_id, r_rd.owner, r_rd.parent};
                end else begin
                    r_res <= '{ST_ABSENT, r_req.target_id, '0, '0};
                end
            end
            // hold the beat until taken, then load the next result
            if (r_state == S_DONE && out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && req_beat) begin
            r_req <= i_req.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK) begin
            mem[pick_id] <= '{r_req.owner_handle, r_req.parent_id};
        end
        if (r_state == S_FIND) begin
            r_rd <= mem[r_req.target_id];
        end
    end

`ifndef ASSERT_OFF
    a_rsvd_never_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> ((r_occ[0] & ROW_RSVD) == '0))
        else $error("reserved identifier marked occupied");

    a_grp0_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_grp_full[0] == &(r_occ[0] | ROW_RSVD)))
        else $error("group full flag out of step with occupancy row");

    a_pick_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |=> r_occ[$past(r_grp)][$past(pick_bit)])
        else $error("allocated identifier not marked occupied");

    a_alloc_id_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |=> (CMP_W'(r_res.result_id) >= CMP_W'(FIRST_ID)))
        else $error("allocated identifier below first usable id");
`endif

endmodule

`default_nettype wire

[test/tb_process_id_allocator_top.sv]
// ----------------------------------------------------------------------------
// Process ID allocator testbench
// Drives request beats with random gaps and response stalls, keeps its own
// copy of the occupancy map and owner/parent stores, and checks every
// response beat field by field against the predicted answer, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_process_id_allocator_top;
    import pia_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pia_req_if req_ch ();
    pia_rsp_if rsp_ch ();

    process_id_allocator_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    bit                 id_taken  [NUM_IDS];
    logic [OWNER_W-1:0] owner_of  [NUM_IDS];
    logic [ID_W-1:0]    parent_of [NUM_IDS];

    t_rsp pending_answers[$];
    int   fail_count     = 0;
    int   quiet_cycles   = 0;
    bit   gaps_enabled   = 1'b1;
    bit   stalls_enabled = 1'b1;
    bit   hold_requested = 1'b0;

    function automatic t_rsp id_table_answer(input t_req r);
        t_rsp a;
        int   slot;
        bit   hit;
        a        = '0;
        a.status = ST_ABSENT;
        slot     = -1;
        hit      = (r.target_id >= 1) && (int'(r.target_id) < ID_BOUND)
                   && id_taken[r.target_id];
        case (r.operation)
            OP_ALLOC: begin
                for (int k = ID_BOUND - 1; k >= FIRST_ID; k--) begin
                    if (!id_taken[k]) begin
                        slot = k;
                    end
                end
                if (slot < 0) begin
                    a.status = ST_FULL;
                end else begin
                    id_taken[slot]  = 1'b1;
                    owner_of[slot]  = r.owner_handle;
                    parent_of[slot] = r.parent_id;
                    a.status        = ST_OK;
                    a.result_id     = ID_W'(slot);
                end
            end
            OP_FORGET: begin
                if (hit) begin
                    id_taken[r.target_id] = 1'b0;
                    a.status              = ST_OK;
                end
            end
            OP_LOOKUP: begin
                a.result_id = r.target_id;
                if (hit) begin
                    a.status     = ST_OK;
                    a.owner_out  = owner_of[r.target_id];
                    a.parent_out = parent_of[r.target_id];
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    function automatic t_req make_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid,
                                      input logic [OWNER_W-1:0] owner,
                                      input logic [ID_W-1:0] parent);
        t_req r;
        r.operation    = op;
        r.target_id    = tid;
        r.owner_handle = owner;
        r.parent_id    = parent;
        return r;
    endfunction

    // Mostly occupied identifiers, some edge identifiers, the rest anything.
    function automatic logic [ID_W-1:0] pick_target();
        int start;
        int roll;
        start = $urandom_range(0, NUM_IDS - 1);
        roll  = $urandom_range(0, 99);
        if (roll < 15) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return ID_W'(1);
                2:       return ID_W'(ID_BOUND - 1);
                default: return ID_W'(FIRST_ID);
            endcase
        end
        if (roll < 75) begin
            for (int n = 0; n < NUM_IDS; n++) begin
                if (id_taken[(start + n) % NUM_IDS]) begin
                    return ID_W'((start + n) % NUM_IDS);
                end
            end
        end
        return ID_W'(start);
    endfunction

    task automatic send_request(input t_req r);
        int gap;
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_answers.push_back(id_table_answer(r));
    endtask

    task automatic send_random_request(input int alloc_pct);
        int                roll;
        logic [OP_W-1:0]   op;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            op = OP_ALLOC;
        end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
            op = OP_FORGET;
        end else begin
            op = OP_LOOKUP;
        end
        send_request(make_req(op, (op == OP_ALLOC) ? ID_W'($urandom_range(0, 255))
                                                   : pick_target(),
                              $urandom(), ID_W'($urandom_range(0, 255))));
    endtask

    task automatic check_field(input string name, input logic [OWNER_W-1:0] expv,
                               input logic [OWNER_W-1:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
            fail_count++;
        end
    endtask

    task automatic test_directed_cases();
        send_request(make_req(OP_LOOKUP, '0, 32'hDEAD_BEEF, 8'h11));
        send_request(make_req(OP_LOOKUP, ID_W'(1), 32'h0000_0001, 8'h22));
        send_request(make_req(OP_LOOKUP, ID_W'(ID_BOUND - 1), '1, '1));
        send_request(make_req(OP_FORGET, '0, 32'h8000_0000, 8'h80));
        send_request(make_req(OP_FORGET, ID_W'(ID_BOUND - 1), '0, '0));
        send_request(make_req(OP_ALLOC, ID_W'(ID_BOUND - 1), '0, '0));
        send_request(make_req(OP_ALLOC, '0, '1, '1));
        send_request(make_req(OP_ALLOC, 8'h55, 32'hA5A5_5A5A, ID_W'(1)));
        send_request(make_req(OP_LOOKUP, ID_W'(2), '0, 8'hAA));
        send_request(make_req(OP_LOOKUP, ID_W'(3), 32'h5555_AAAA, 8'h55));
        send_request(make_req(OP_LOOKUP, ID_W'(4), '1, '0));
        send_request(make_req(OP_FORGET, ID_W'(1), 32'h0F0F_0F0F, 8'h0F));
        send_request(make_req(OP_LOOKUP, ID_W'(1), '0, '0));
        send_request(make_req(OP_FORGET, ID_W'(3), '0, '0));
        send_request(make_req(OP_FORGET, ID_W'(3), '1, '1));
        send_request(make_req(OP_LOOKUP, ID_W'(3), '0, '0));
        send_request(make_req(OP_ALLOC, 8'hF0, 32'h1234_5678, 8'h80));
        send_request(make_req(OP_LOOKUP, ID_W'(3), '0, '0));
        send_request(make_req(OP_RESERVED, '1, '1, '1));
        send_request(make_req(OP_ALLOC, 8'h0F, 32'h5A5A_A5A5, 8'h7F));
        send_request(make_req(OP_FORGET, ID_W'(2), '0, '0));
        send_request(make_req(OP_FORGET, ID_W'(4), '0, '0));
        send_request(make_req(OP_LOOKUP, ID_W'(5), '0, '0));
    endtask

    task automatic test_fill_to_full();
        for (int n = 0; n < ID_BOUND; n++) begin
            send_request(make_req(OP_ALLOC, ID_W'($urandom_range(0, 255)), $urandom(),
                                  ID_W'($urandom_range(0, 255))));
        end
        send_request(make_req(OP_LOOKUP, ID_W'(ID_BOUND - 1), '0, '0));
        send_request(make_req(OP_FORGET, ID_W'(ID_BOUND - 1), '0, '0));
        send_request(make_req(OP_ALLOC, '0, $urandom(), ID_W'($urandom_range(0, 255))));
        send_request(make_req(OP_ALLOC, '0, $urandom(), ID_W'($urandom_range(0, 255))));
        send_request(make_req(OP_FORGET, ID_W'(FIRST_ID), '0, '0));
        send_request(make_req(OP_LOOKUP, ID_W'(FIRST_ID), '0, '0));
        send_request(make_req(OP_LOOKUP, ID_W'(1), '0, '0));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            for (int n = 0; n < 45; n++) begin
                send_random_request((phase % 2 == 0) ? 10 : 65);
            end
        end
    endtask

    task automatic test_output_backpressure();
        gaps_enabled   = 1'b0;
        hold_requested = 1'b1;
        for (int n = 0; n < 24; n++) begin
            send_random_request(50);
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_streaming_tail();
        gaps_enabled   = 1'b0;
        stalls_enabled = 1'b0;
        for (int n = 0; n < 60; n++) begin
            send_random_request(40);
        end
    endtask

    initial begin : response_ready_driver
        int stall;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requested) begin
                hold_requested = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else if (stalls_enabled && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 14);
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : response_check
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected response beat: status %0d result_id %0d",
                       rsp_ch.payload.status, rsp_ch.payload.result_id);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                check_field("status", OWNER_W'(want.status), OWNER_W'(rsp_ch.payload.status));
                check_field("result_id", OWNER_W'(want.result_id),
                            OWNER_W'(rsp_ch.payload.result_id));
                check_field("owner_out", want.owner_out, rsp_ch.payload.owner_out);
                check_field("parent_out", OWNER_W'(want.parent_out),
                            OWNER_W'(rsp_ch.payload.parent_out));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_tests
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_to_full();
        test_random_traffic();
        test_output_backpressure();
        test_streaming_tail();

        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/pia_pkg.sv
hdl/pia_req_if.sv
hdl/pia_rsp_if.sv
hdl/process_id_allocator_top.sv
test/tb_process_id_allocator_top.sv
